/* rtl/core/tsp_pkg.sv */
//==============================================================================
// tsp_pkg: shared types and tables for the timestamp text parser
// Holds status codes, parse phases, the record passed from the parser front
// to the epoch back end, and the small calendar and scaling tables.
//==============================================================================
`default_nettype none

package tsp_pkg;

   localparam int MAX_FRACTION_DIGITS = 9;
   localparam int QUEUE_DEPTH         = 4;
   localparam int QUEUE_AW            = $clog2(QUEUE_DEPTH);

   typedef enum logic [2:0] {
      ST_OK        = 3'd0,
      ST_FORMAT    = 3'd1,
      ST_RANGE     = 3'd2,
      ST_LEAP      = 3'd3,
      ST_DATE      = 3'd4,
      ST_FRAC_LONG = 3'd5,
      ST_OFFSET    = 3'd6
   } status_type;

   typedef enum logic [2:0] {
      PH_HEAD       = 3'd0,
      PH_AFTER_HEAD = 3'd1,
      PH_DOT        = 3'd2,
      PH_FRAC       = 3'd3,
      PH_OFFSET     = 3'd4,
      PH_END        = 3'd5
   } phase_type;

   // One parsed timestamp, handed from the parser to the arithmetic.
   typedef struct packed {
      status_type  status;
      logic [13:0] year;
      logic [6:0]  month;
      logic [6:0]  day;
      logic [6:0]  hour;
      logic [6:0]  minute;
      logic [6:0]  second;
      logic [29:0] fraction;
      logic [3:0]  frac_digits;
      logic        leap;
   } record_type;

   // Floor of x / 100 for x below 16384, by reciprocal multiplication.
   function automatic logic [14:0] div100(input logic [14:0] x);
      logic [27:0] prod;
      prod = 28'(x) * 28'd5243;
      return 15'(prod >> 19);
   endfunction

   // Gregorian leap year test for years 0..9999.
   function automatic logic leap_year(input logic [13:0] y);
      logic [14:0] q;
      logic [14:0] r;
      q = div100({1'b0, y});
      r = 15'({1'b0, y} - 15'(q * 15'd100));
      return (y[1:0] == 2'b00 && r != 15'd0) || (r == 15'd0 && q[1:0] == 2'b00);
   endfunction

   function automatic logic [4:0] month_len(input logic [3:0] m);
      case (m)
         4'd2:    return 5'd28;
         4'd4:    return 5'd30;
         4'd6:    return 5'd30;
         4'd9:    return 5'd30;
         4'd11:   return 5'd30;
         default: return 5'd31;
      endcase
   endfunction

   function automatic logic [8:0] month_start(input logic [3:0] m);
      case (m)
         4'd2:    return 9'd31;
         4'd3:    return 9'd59;
         4'd4:    return 9'd90;
         4'd5:    return 9'd120;
         4'd6:    return 9'd151;
         4'd7:    return 9'd181;
         4'd8:    return 9'd212;
         4'd9:    return 9'd243;
         4'd10:   return 9'd273;
         4'd11:   return 9'd304;
         4'd12:   return 9'd334;
         default: return 9'd0;
      endcase
   endfunction

   // Scale factor 10^(9 - n) that turns n fraction digits into nanoseconds.
   function automatic logic [29:0] frac_scale(input logic [3:0] n);
      case (n)
         4'd0:    return 30'd1000000000;
         4'd1:    return 30'd100000000;
         4'd2:    return 30'd10000000;
         4'd3:    return 30'd1000000;
         4'd4:    return 30'd100000;
         4'd5:    return 30'd10000;
         4'd6:    return 30'd1000;
         4'd7:    return 30'd100;
         4'd8:    return 30'd10;
         default: return 30'd1;
      endcase
   endfunction

endpackage

`default_nettype wire

/* rtl/core/tsp_front.sv */
//==============================================================================
// tsp_front: character parser
// Consumes one character per beat, keeps the field accumulators and the first
// error, and emits one record on the final character.
//==============================================================================
`default_nettype none

module tsp_front (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                strict,
   input  wire logic                take,
   input  wire logic [7:0]          char_byte,
   input  wire logic                last_char,
   output logic                     push,
   output tsp_pkg::record_type      rec
);

   tsp_pkg::phase_type  phase_ff, phase_in;
   tsp_pkg::status_type err_ff, err_in;
   logic [4:0]  pos_ff, pos_in;
   logic [13:0] year_ff, year_in;
   logic [6:0]  month_ff, month_in, day_ff, day_in, hour_ff, hour_in;
   logic [6:0]  minute_ff, minute_in, second_ff, second_in;
   logic [29:0] frac_ff, frac_in;
   logic [3:0]  ndig_ff, ndig_in;
   logic        offnz_ff, offnz_in;

   logic        is_dig;
   logic [3:0]  dval;
   logic        leap;
   logic [4:0]  dim;

   assign is_dig = char_byte >= 8'h30 && char_byte <= 8'h39;
   assign dval   = char_byte[3:0];
   assign leap   = tsp_pkg::leap_year(year_ff);

   // Next parse state for the character on the input.
   always_comb begin
      phase_in  = phase_ff;
      err_in    = err_ff;
      pos_in    = pos_ff;
      year_in   = year_ff;
      month_in  = month_ff;
      day_in    = day_ff;
      hour_in   = hour_ff;
      minute_in = minute_ff;
      second_in = second_ff;
      frac_in   = frac_ff;
      ndig_in   = ndig_ff;
      offnz_in  = offnz_ff;
      dim       = 5'd31;
      case (phase_ff)
         tsp_pkg::PH_HEAD: begin
            if (pos_ff == 5'd4 || pos_ff == 5'd7) begin
               if (char_byte != 8'h2D && err_in == tsp_pkg::ST_OK) err_in = tsp_pkg::ST_FORMAT;
            end else if (pos_ff == 5'd10) begin
               if (char_byte != 8'h54 && err_in == tsp_pkg::ST_OK) err_in = tsp_pkg::ST_FORMAT;
            end else if (pos_ff == 5'd13 || pos_ff == 5'd16) begin
               if (char_byte != 8'h3A && err_in == tsp_pkg::ST_OK) err_in = tsp_pkg::ST_FORMAT;
            end else if (!is_dig) begin
               if (err_in == tsp_pkg::ST_OK) err_in = tsp_pkg::ST_FORMAT;
            end else if (pos_ff < 5'd4) begin
               year_in = 14'(year_ff * 14'd10 + 14'(dval));
            end else if (pos_ff < 5'd7) begin
               month_in = 7'(month_ff * 7'd10 + 7'(dval));
            end else if (pos_ff < 5'd10) begin
               day_in = 7'(day_ff * 7'd10 + 7'(dval));
            end else if (pos_ff < 5'd13) begin
               hour_in = 7'(hour_ff * 7'd10 + 7'(dval));
            end else if (pos_ff < 5'd16) begin
               minute_in = 7'(minute_ff * 7'd10 + 7'(dval));
            end else begin
               second_in = 7'(second_ff * 7'd10 + 7'(dval));
            end
            if (pos_ff >= 5'd18) begin
               phase_in = tsp_pkg::PH_AFTER_HEAD;
               pos_in   = 5'd0;
               if (err_in == tsp_pkg::ST_OK) begin
                  dim = (month_ff == 7'd2 && leap) ? 5'd29 : tsp_pkg::month_len(month_ff[3:0]);
                  if (hour_in > 7'd23 || minute_in > 7'd59 || second_in > 7'd60)
                     err_in = tsp_pkg::ST_RANGE;
                  else if (second_in == 7'd60)
                     err_in = tsp_pkg::ST_LEAP;
                  else if (month_in < 7'd1 || month_in > 7'd12 || day_in < 7'd1)
                     err_in = tsp_pkg::ST_DATE;
                  else if (day_in > 7'(dim))
                     err_in = tsp_pkg::ST_DATE;
               end
            end else begin
               pos_in = 5'(pos_ff + 5'd1);
            end
         end
         tsp_pkg::PH_DOT, tsp_pkg::PH_FRAC, tsp_pkg::PH_AFTER_HEAD: begin
            if (phase_ff == tsp_pkg::PH_AFTER_HEAD && char_byte == 8'h2E) begin
               phase_in = tsp_pkg::PH_DOT;
            end else if (phase_ff != tsp_pkg::PH_AFTER_HEAD && is_dig) begin
               phase_in = tsp_pkg::PH_FRAC;
               if (ndig_ff < 4'(tsp_pkg::MAX_FRACTION_DIGITS)) begin
                  frac_in = 30'(frac_ff * 30'd10 + 30'(dval));
                  ndig_in = 4'(ndig_ff + 4'd1);
               end else if (ndig_ff == 4'(tsp_pkg::MAX_FRACTION_DIGITS)) begin
                  ndig_in = 4'(ndig_ff + 4'd1);
                  if (strict && err_in == tsp_pkg::ST_OK) err_in = tsp_pkg::ST_FRAC_LONG;
               end
            end else if (phase_ff == tsp_pkg::PH_DOT) begin
               if (err_in == tsp_pkg::ST_OK) err_in = tsp_pkg::ST_FORMAT;
               phase_in = tsp_pkg::PH_END;
            end else if (char_byte == 8'h5A) begin
               phase_in = tsp_pkg::PH_END;
            end else if (char_byte == 8'h7A) begin
               if (strict && err_in == tsp_pkg::ST_OK) err_in = tsp_pkg::ST_FORMAT;
               phase_in = tsp_pkg::PH_END;
            end else if (char_byte == 8'h2B || char_byte == 8'h2D) begin
               phase_in = tsp_pkg::PH_OFFSET;
               pos_in   = 5'd1;
            end else begin
               if (err_in == tsp_pkg::ST_OK) err_in = tsp_pkg::ST_FORMAT;
               phase_in = tsp_pkg::PH_END;
            end
         end
         tsp_pkg::PH_OFFSET: begin
            if (pos_ff == 5'd3) begin
               if (char_byte != 8'h3A && err_in == tsp_pkg::ST_OK) err_in = tsp_pkg::ST_FORMAT;
            end else if (!is_dig) begin
               if (err_in == tsp_pkg::ST_OK) err_in = tsp_pkg::ST_FORMAT;
            end else if (char_byte != 8'h30) begin
               offnz_in = 1'b1;
            end
            if (pos_ff >= 5'd5) begin
               if ((offnz_in || strict) && err_in == tsp_pkg::ST_OK) err_in = tsp_pkg::ST_OFFSET;
               phase_in = tsp_pkg::PH_END;
               pos_in   = 5'd0;
            end else begin
               pos_in = 5'(pos_ff + 5'd1);
            end
         end
         default: begin
            if (err_in == tsp_pkg::ST_OK) err_in = tsp_pkg::ST_FORMAT;
         end
      endcase
   end

   // Record for the final character, with the end-of-text status.
   always_comb begin
      push            = take && last_char;
      rec.year        = year_in;
      rec.month       = month_in;
      rec.day         = day_in;
      rec.hour        = hour_in;
      rec.minute      = minute_in;
      rec.second      = second_in;
      rec.fraction    = frac_in;
      rec.frac_digits = (ndig_in > 4'(tsp_pkg::MAX_FRACTION_DIGITS)) ?
                        4'(tsp_pkg::MAX_FRACTION_DIGITS) : ndig_in;
      rec.leap        = tsp_pkg::leap_year(year_in);
      if (err_in != tsp_pkg::ST_OK) begin
         rec.status = err_in;
      end else begin
         case (phase_in)
            tsp_pkg::PH_HEAD, tsp_pkg::PH_DOT, tsp_pkg::PH_OFFSET:
               rec.status = tsp_pkg::ST_FORMAT;
            tsp_pkg::PH_AFTER_HEAD, tsp_pkg::PH_FRAC:
               rec.status = strict ? tsp_pkg::ST_FORMAT : tsp_pkg::ST_OK;
            default:
               rec.status = tsp_pkg::ST_OK;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset || push) begin
         phase_ff  <= tsp_pkg::PH_HEAD;
         err_ff    <= tsp_pkg::ST_OK;
         pos_ff    <= 5'd0;
         year_ff   <= 14'd0;
         month_ff  <= 7'd0;
         day_ff    <= 7'd0;
         hour_ff   <= 7'd0;
         minute_ff <= 7'd0;
         second_ff <= 7'd0;
         frac_ff   <= 30'd0;
         ndig_ff   <= 4'd0;
         offnz_ff  <= 1'b0;
      end else if (take) begin
         phase_ff  <= phase_in;
         err_ff    <= err_in;
         pos_ff    <= pos_in;
         year_ff   <= year_in;
         month_ff  <= month_in;
         day_ff    <= day_in;
         hour_ff   <= hour_in;
         minute_ff <= minute_in;
         second_ff <= second_in;
         frac_ff   <= frac_in;
         ndig_ff   <= ndig_in;
         offnz_ff  <= offnz_in;
      end
   end

endmodule

`default_nettype wire

/* rtl/core/tsp_queue.sv */
//==============================================================================
// tsp_queue: record queue
// Small first-in first-out buffer between the parser and the arithmetic.
//==============================================================================
`default_nettype none

module tsp_queue (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                push,
   input  tsp_pkg::record_type      push_rec,
   input  wire logic                pop,
   output logic                     full,
   output logic                     empty,
   output tsp_pkg::record_type      head_rec
);

   tsp_pkg::record_type          mem_ff [tsp_pkg::QUEUE_DEPTH];
   logic [tsp_pkg::QUEUE_AW-1:0] wptr_ff, rptr_ff;
   logic [tsp_pkg::QUEUE_AW:0]   count_ff;

   assign full     = count_ff == (tsp_pkg::QUEUE_AW+1)'(tsp_pkg::QUEUE_DEPTH);
   assign empty    = count_ff == '0;
   assign head_rec = mem_ff[rptr_ff];

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wptr_ff] <= push_rec;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wptr_ff  <= '0;
         rptr_ff  <= '0;
         count_ff <= '0;
      end else begin
         if (push) wptr_ff <= wptr_ff + 1'b1;
         if (pop)  rptr_ff <= rptr_ff + 1'b1;
         if (push && !pop)      count_ff <= count_ff + 1'b1;
         else if (pop && !push) count_ff <= count_ff - 1'b1;
      end
   end

endmodule

`default_nettype wire

/* rtl/core/tsp_back.sv */
//==============================================================================
// tsp_back: epoch arithmetic
// Three-stage stallable pipeline turning a parsed record into epoch seconds
// and nanoseconds; the last stage is the output register.
//==============================================================================
`default_nettype none

module tsp_back (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                q_empty,
   input  tsp_pkg::record_type      q_rec,
   output logic                     pop,
   output logic                     out_valid,
   input  wire logic                out_ready,
   output logic [2:0]               out_status,
   output logic [38:0]              out_secs,
   output logic [29:0]              out_nanos
);

   logic advance;

   // Stage 1: year to day count.
   logic                v1_ff;
   tsp_pkg::record_type r1_ff;
   logic [21:0]         yd1_ff, yd1_in;
   logic [14:0]         q100, q400;

   // Stage 2: full day count, time of day, nanoseconds.
   logic                v2_ff;
   logic [2:0]          st2_ff;
   logic [22:0]         days2_ff, days2_in;
   logic [16:0]         hms2_ff, hms2_in;
   logic [29:0]         ns2_ff, ns2_in;
   logic [3:0]          m1;
   logic [59:0]         nsprod;

   // Stage 3: output register.
   logic                v3_ff;
   logic [2:0]          st3_ff;
   logic [38:0]         secs3_ff, secs3_in;
   logic [29:0]         ns3_ff;

   assign advance = !v3_ff || out_ready;
   assign pop     = advance && !q_empty;

   always_comb begin
      q100   = tsp_pkg::div100(15'(q_rec.year) + 15'd99);
      q400   = tsp_pkg::div100((15'(q_rec.year) + 15'd399) >> 2);
      yd1_in = 22'(22'(q_rec.year) * 22'd365 + 22'((15'(q_rec.year) + 15'd3) >> 2)
               - 22'(q100) + 22'(q400));
   end

   always_comb begin
      m1 = (r1_ff.month >= 7'd1 && r1_ff.month <= 7'd12) ? r1_ff.month[3:0] : 4'd1;
      days2_in = 23'(23'(yd1_ff) + 23'(tsp_pkg::month_start(m1)) + 23'(r1_ff.day) - 23'd1
                 + ((m1 > 4'd2 && r1_ff.leap) ? 23'd1 : 23'd0) - 23'd719528);
      hms2_in  = 17'(17'(r1_ff.hour) * 17'd3600 + 17'(r1_ff.minute) * 17'd60
                 + 17'(r1_ff.second));
      nsprod   = 60'(r1_ff.fraction) * 60'(tsp_pkg::frac_scale(r1_ff.frac_digits));
      ns2_in   = nsprod[29:0];
   end

   assign secs3_in = 39'({{16{days2_ff[22]}}, days2_ff} * 39'd86400) + 39'(hms2_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
      end else if (advance) begin
         v1_ff <= pop;
         v2_ff <= v1_ff;
         v3_ff <= v2_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         r1_ff    <= q_rec;
         yd1_ff   <= yd1_in;
         st2_ff   <= r1_ff.status;
         days2_ff <= days2_in;
         hms2_ff  <= hms2_in;
         ns2_ff   <= ns2_in;
         st3_ff   <= st2_ff;
         secs3_ff <= (st2_ff == tsp_pkg::ST_OK) ? secs3_in : 39'd0;
         ns3_ff   <= (st2_ff == tsp_pkg::ST_OK) ? ns2_ff : 30'd0;
      end
   end

   assign out_valid  = v3_ff;
   assign out_status = st3_ff;
   assign out_secs   = secs3_ff;
   assign out_nanos  = ns3_ff;

endmodule

`default_nettype wire

/* rtl/core/timestamp_text_parser.sv */
//==============================================================================
// timestamp_text_parser: streaming date-time text to epoch converter
// Parses one character per beat and returns status, seconds and nanoseconds.
//==============================================================================
// Throughput: one character beat per cycle while the queue has room, also across texts.
// Path: the record enters the queue at the edge that takes the final character,
// then passes three arithmetic stages, the last being the output register.
// Reset: synchronous, active high; clears the parser, queue and pipeline and
// sets strict mode.
`default_nettype none

module timestamp_text_parser (
   input  wire logic        clock,
   input  wire logic        reset,
   // Configuration: csr_data[0] is strict_mode.
   input  wire logic        csr_valid,
   output logic             csr_ready,
   input  wire logic [0:0]  csr_data,
   // Character stream.
   input  wire logic        req_tvalid,
   output logic             req_tready,
   input  wire logic [7:0]  req_tdata,   // [7:0] char_byte
   input  wire logic        req_tlast,   // last_char
   // Results.
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   output logic [71:0]      rsp_tdata    // [2:0] status, [41:3] epoch_seconds,
                                         // [71:42] fraction_nanos
);

   logic                strict_ff;
   logic                take;
   logic                push;
   logic                q_full, q_empty, pop;
   tsp_pkg::record_type push_rec, head_rec;
   logic [2:0]          status;
   logic [38:0]         secs;
   logic [29:0]         nanos;

   // The mode register is always writable; the parser reads it live.
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         strict_ff <= 1'b1;
      end else if (csr_valid) begin
         strict_ff <= csr_data[0];
      end
   end

   // A beat is taken whenever the queue has room for a possible record, so
   // the front keeps running while the back end waits on the consumer.
   assign req_tready = !q_full;
   assign take       = req_tvalid && req_tready;

   tsp_front u_front (
      .clock     (clock),
      .reset     (reset),
      .strict    (strict_ff),
      .take      (take),
      .char_byte (req_tdata),
      .last_char (req_tlast),
      .push      (push),
      .rec       (push_rec)
   );

   tsp_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (push),
      .push_rec (push_rec),
      .pop      (pop),
      .full     (q_full),
      .empty    (q_empty),
      .head_rec (head_rec)
   );

   tsp_back u_back (
      .clock      (clock),
      .reset      (reset),
      .q_empty    (q_empty),
      .q_rec      (head_rec),
      .pop        (pop),
      .out_valid  (rsp_tvalid),
      .out_ready  (rsp_tready),
      .out_status (status),
      .out_secs   (secs),
      .out_nanos  (nanos)
   );

   assign rsp_tdata = {nanos, secs, status};

endmodule

`default_nettype wire
